/* design/hte_pkg.sv */
// hte_pkg: shared types, constants and helpers for the hashtag extractor.
// Used by hte_scanner, hte_out_fifo and hashtag_extractor; depends on nothing.
package hte_pkg;

    // default sizing, handed down from the top level parameters
    localparam int MAX_TAGS_DEF      = 32;
    localparam int MAX_TAG_BYTES_DEF = 128;
    localparam int TEXT_BYTES_DEF    = 4096;

    localparam int PREFIX_BYTES = 7;
    localparam logic [7:0] BODY_LEN_MAX = 8'd255;
    localparam logic [5:0] COUNT_MAX    = 6'd63;

    // result queue
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
    // one item in the input register plus one being accepted: two results each
    localparam int ACCEPT_LEVEL = OUT_DEPTH - 4;

    // register map
    localparam logic [1:0] REG_SKIP_PREFIX  = 2'd0;
    localparam logic [1:0] REG_LEN_LIMIT    = 2'd1;
    localparam logic [1:0] REG_COUNT_LIMIT  = 2'd2;

    localparam logic [55:0] SKIP_PREFIX_RST = 56'd13345264121768051;
    localparam logic [7:0]  LEN_LIMIT_RST   = 8'd128;
    localparam logic [5:0]  COUNT_LIMIT_RST = 6'd32;

    // byte codes
    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    localparam logic KIND_TAG     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        SCAN_OUT  = 3'b001,
        SCAN_TAG  = 3'b010,
        SCAN_STOP = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  tag_number;
        logic [11:0] tag_start;
        logic [6:0]  tag_length;
        logic [5:0]  tag_count;
        logic        limit_reached;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [55:0] skip_prefix;
        logic [7:0]  tag_length_limit;
        logic [5:0]  tag_count_limit;
    } cfg_t;

    // up to two results per byte, tag result ahead of summary
    typedef struct packed {
        logic    tag_valid;
        logic    sum_valid;
        result_t tag_res;
        result_t sum_res;
    } push_t;

    function automatic logic is_stop_byte(input logic [7:0] c);
        logic ws;
        ws = (c == CH_END) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        return ws || (c == CH_COMMA) || (c == CH_PERIOD) || (c == CH_SEMI) ||
               (c == CH_COLON) || (c == CH_BANG) || (c == CH_QUESTION) ||
               (c == CH_RPAREN) || (c == CH_RBRACKET) || (c == CH_RBRACE);
    endfunction

endpackage

/* design/hte_scanner.sv */
// hte_scanner: input byte register and per-text scan state; emits tag and
// summary results for each registered byte. Depends on hte_pkg.
module hte_scanner #(
    parameter int MAX_TAGS      = hte_pkg::MAX_TAGS_DEF,
    parameter int MAX_TAG_BYTES = hte_pkg::MAX_TAG_BYTES_DEF,
    parameter int TEXT_BYTES    = hte_pkg::TEXT_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_load,
    input  logic [7:0]     in_byte,
    input  hte_pkg::cfg_t  cfg,
    output hte_pkg::push_t push
);

    localparam int POS_W = $clog2(TEXT_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_BYTES - 1);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;

    hte_pkg::scan_mode_t mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [7:0]          len_reg, len_next;
    logic                match_reg, match_next;
    logic [5:0]          count_reg, count_next;
    logic                stopped_reg, stopped_next;

    logic        is_end;
    logic        stop;
    logic        too_long;
    logic        count_full;
    logic        metadata;
    logic [63:0] prefix_ext;
    logic [7:0]  want;

    assign is_end     = (in_byte_reg == hte_pkg::CH_END);
    assign stop       = hte_pkg::is_stop_byte(in_byte_reg);
    assign too_long   = (len_reg >= cfg.tag_length_limit) ||
                        (16'(len_reg) >= 16'(MAX_TAG_BYTES));
    assign count_full = (count_reg >= cfg.tag_count_limit) ||
                        (16'(count_reg) >= 16'(MAX_TAGS));
    assign metadata   = (len_reg >= 8'(hte_pkg::PREFIX_BYTES)) && match_reg;
    assign prefix_ext = {8'h00, cfg.skip_prefix};
    assign want       = prefix_ext[{len_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        push         = '0;

        if (in_valid_reg)
        begin
            unique case (mode_reg)
                hte_pkg::SCAN_TAG:
                begin
                    if (stop)
                    begin
                        mode_next = hte_pkg::SCAN_OUT;
                        if (len_reg == 8'd0 || metadata || too_long)
                        begin
                            // dropped
                        end
                        else if (count_full)
                        begin
                            mode_next    = hte_pkg::SCAN_STOP;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            if (count_reg < hte_pkg::COUNT_MAX)
                                count_next = count_reg + 6'd1;
                            push.tag_valid             = 1'b1;
                            push.tag_res.kind          = hte_pkg::KIND_TAG;
                            push.tag_res.tag_number    = count_reg[4:0];
                            push.tag_res.tag_start     = 12'(32'(start_reg));
                            push.tag_res.tag_length    = len_reg[6:0];
                            push.tag_res.tag_count     = count_next;
                            push.tag_res.limit_reached = 1'b0;
                            push.tag_res.last          = !is_end;
                        end
                    end
                    else
                    begin
                        if (len_reg < 8'(hte_pkg::PREFIX_BYTES) && want != in_byte_reg)
                            match_next = 1'b0;
                        if (len_reg != hte_pkg::BODY_LEN_MAX)
                            len_next = len_reg + 8'd1;
                    end
                end
                hte_pkg::SCAN_STOP:
                begin
                    // rest of the text is ignored
                end
                default:
                begin
                    if (in_byte_reg == hte_pkg::CH_HASH)
                    begin
                        mode_next  = hte_pkg::SCAN_TAG;
                        start_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : POS_MAX;
                        len_next   = 8'd0;
                        match_next = 1'b1;
                    end
                end
            endcase

            if (is_end)
            begin
                push.sum_valid             = 1'b1;
                push.sum_res.kind          = hte_pkg::KIND_SUMMARY;
                push.sum_res.tag_count     = count_next;
                push.sum_res.limit_reached = stopped_next;
                push.sum_res.last          = 1'b1;
                mode_next    = hte_pkg::SCAN_OUT;
                pos_next     = '0;
                start_next   = '0;
                len_next     = 8'd0;
                match_next   = 1'b1;
                count_next   = 6'd0;
                stopped_next = 1'b0;
            end
            else if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= hte_pkg::SCAN_OUT;
            pos_reg      <= '0;
            start_reg    <= '0;
            len_reg      <= 8'd0;
            match_reg    <= 1'b1;
            count_reg    <= 6'd0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_load;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            match_reg    <= match_next;
            count_reg    <= count_next;
            stopped_reg  <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_byte_reg <= in_byte;
    end

`ifndef SYNTHESIS
    // end of text returns all per-text state to its idle values
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_byte_reg == hte_pkg::CH_END) |=>
        (count_reg == 6'd0 && mode_reg == hte_pkg::SCAN_OUT && !stopped_reg))
        else $error("scan state not cleared after end of text");

    // the stop flag and the stopped mode always travel together
    a_stop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg == (mode_reg == hte_pkg::SCAN_STOP))
        else $error("stop flag and scan mode disagree");
`endif

endmodule

/* design/hte_out_fifo.sv */
// hte_out_fifo: eight-entry result queue taking up to two results a cycle
// and presenting one on the master stream side. Depends on hte_pkg.
module hte_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  hte_pkg::push_t    push,
    input  logic              pop_ready,
    output logic              head_valid,
    output hte_pkg::result_t  head,
    output logic              room
);

    hte_pkg::result_t mem [hte_pkg::OUT_DEPTH];

    logic [hte_pkg::OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hte_pkg::OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hte_pkg::OUT_CNT_W-1:0] count_reg, count_next;
    logic [1:0]                    push_n;
    logic                          pop;
    logic [hte_pkg::OUT_PTR_W-1:0] wr_ptr_inc;

    assign push_n      = {1'b0, push.tag_valid} + {1'b0, push.sum_valid};
    assign head_valid  = (count_reg != '0);
    assign pop         = head_valid && pop_ready;
    assign head        = mem[rd_ptr_reg];
    assign room        = (count_reg <= hte_pkg::OUT_CNT_W'(hte_pkg::ACCEPT_LEVEL));
    assign wr_ptr_inc  = wr_ptr_reg + hte_pkg::OUT_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + hte_pkg::OUT_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + hte_pkg::OUT_PTR_W'(pop);
    assign count_next  = count_reg + hte_pkg::OUT_CNT_W'(push_n)
                         - hte_pkg::OUT_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.tag_valid && push.sum_valid)
        begin
            mem[wr_ptr_reg] <= push.tag_res;
            mem[wr_ptr_inc] <= push.sum_res;
        end
        else if (push.tag_valid)
        begin
            mem[wr_ptr_reg] <= push.tag_res;
        end
        else if (push.sum_valid)
        begin
            mem[wr_ptr_reg] <= push.sum_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // the accept threshold must leave room for every push, even with no pop
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (hte_pkg::OUT_CNT_W + 1)'(push_n)) <=
        (hte_pkg::OUT_CNT_W + 1)'(hte_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    // fill level and pointers stay in step
    a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != hte_pkg::OUT_CNT_W'(hte_pkg::OUT_DEPTH)) |->
        ((hte_pkg::OUT_PTR_W'(wr_ptr_reg - rd_ptr_reg)) ==
         hte_pkg::OUT_PTR_W'(count_reg)))
        else $error("result queue pointers out of step with fill level");
`endif

endmodule

/* design/hashtag_extractor.sv */
// hashtag_extractor: top level with the APB register file, scanner and
// result queue. Depends on hte_pkg, hte_scanner and hte_out_fifo.
//
// Timing: an accepted byte is captured in the scanner input register and scanned
// from there; its results are written into the result queue, and with an empty
// queue m_tvalid rises as soon as they are written.
// Throughput: one byte per cycle; s_tready drops only while more than four of
// the eight result queue entries are occupied (a stalled m_tready).
// Reset: rst_n is asynchronous, active low; it clears scan state and the queue
// and loads register defaults. No clearing pass: the block is ready at once.
module hashtag_extractor #(
    parameter int MAX_TAGS      = hte_pkg::MAX_TAGS_DEF,
    parameter int MAX_TAG_BYTES = hte_pkg::MAX_TAG_BYTES_DEF,
    parameter int TEXT_BYTES    = hte_pkg::TEXT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // APB configuration port, registers at byte addresses 0, 8, 16
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [4:0] tag_number, [16:5] tag_start,
                                    // [23:17] tag_length, [29:24] tag_count,
                                    // [30] limit_reached, [31] zero
    output logic        m_tuser,    // [0] kind: 0 tag, 1 end-of-text summary
    output logic        m_tlast     // final result for the input byte
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; the scanner
    // reads them directly. The user must change them only while idle; unchecked.
    // ---------------------------------------------------------------
    logic [55:0] skip_prefix_reg;
    logic [7:0]  len_limit_reg;
    logic [5:0]  count_limit_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_prefix_reg <= hte_pkg::SKIP_PREFIX_RST;
            len_limit_reg   <= hte_pkg::LEN_LIMIT_RST;
            count_limit_reg <= hte_pkg::COUNT_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                hte_pkg::REG_SKIP_PREFIX: skip_prefix_reg <= pwdata[55:0];
                hte_pkg::REG_LEN_LIMIT:   len_limit_reg   <= pwdata[7:0];
                hte_pkg::REG_COUNT_LIMIT: count_limit_reg <= pwdata[5:0];
                default:
                begin
                    // unmapped address: write dropped
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hte_pkg::REG_SKIP_PREFIX: prdata = {8'h00, skip_prefix_reg};
            hte_pkg::REG_LEN_LIMIT:   prdata = {56'd0, len_limit_reg};
            hte_pkg::REG_COUNT_LIMIT: prdata = {58'd0, count_limit_reg};
            default:                  prdata = 64'd0;
        endcase
    end

    hte_pkg::cfg_t cfg;

    assign cfg.skip_prefix      = skip_prefix_reg;
    assign cfg.tag_length_limit = len_limit_reg;
    assign cfg.tag_count_limit  = count_limit_reg;

    // ---------------------------------------------------------------
    // Scanner: input register plus scan state; up to two results per
    // byte (a closing tag, then the summary on the end-of-text byte).
    // ---------------------------------------------------------------
    hte_pkg::push_t   push;
    hte_pkg::result_t head;
    logic             room;
    logic             in_load;

    assign s_tready = room;
    assign in_load  = s_tvalid && s_tready;

    hte_scanner #(
        .MAX_TAGS      (MAX_TAGS),
        .MAX_TAG_BYTES (MAX_TAG_BYTES),
        .TEXT_BYTES    (TEXT_BYTES)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_load (in_load),
        .in_byte (s_tdata),
        .cfg     (cfg),
        .push    (push)
    );

    // ---------------------------------------------------------------
    // Result queue: decouples the scanner from output back-pressure.
    // ---------------------------------------------------------------
    hte_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .room       (room)
    );

    assign m_tdata = {1'b0, head.limit_reached, head.tag_count, head.tag_length,
                      head.tag_start, head.tag_number};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
